[design/sha1he_pkg.sv]
// shared constants and types for the sha-1 hash engine
`default_nettype none
package sha1he_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int BLK_WORDS  = 16;
  localparam int WORD_IDX_W = 4;
  localparam int BLK_SLOTS  = 2;
  localparam int SLOT_W     = 1;
  localparam int USED_W     = $clog2(BLK_SLOTS + 1);
  localparam int RAM_DEPTH  = BLK_SLOTS * BLK_WORDS;
  localparam int RAM_AW     = SLOT_W + WORD_IDX_W;
  localparam int NUM_ROUNDS = 80;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic final_blk;
  } blk_desc_t;

endpackage
`default_nettype wire

[design/sha1he_ram.sv]
// generic single write port, single registered read port ram
`default_nettype none
module sha1he_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/sha1he_fifo.sv]
// small register fifo for block descriptors between front and core
`default_nettype none
module sha1he_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("descriptor fifo overflow");

endmodule
`default_nettype wire

[design/sha1he_front.sv]
// front end: byte packing, byte count, padding and block buffer writes
`default_nettype none
module sha1he_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  byte_present,
  input  wire logic                  last,
  output logic                       full,
  input  wire logic                  desc_full,
  input  wire logic                  blk_done,
  output logic                       desc_push,
  output sha1he_pkg::blk_desc_t      desc,
  output sha1he_pkg::ram_wr_t        wr
);
  import sha1he_pkg::*;

  localparam logic ST_DATA = 1'b0;
  localparam logic ST_PAD  = 1'b1;

  logic                  state;
  logic [63:0]           byte_cnt;
  logic [23:0]           acc;
  logic [SLOT_W-1:0]     slot;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     used_next;
  logic [WORD_IDX_W-1:0] pidx;
  logic                  first;
  logic                  lenblk;
  logic [63:0]           len;

  logic                  slot_free;
  logic                  accept;
  logic                  take_byte;
  logic [63:0]           cnt_inc;
  logic [63:0]           n;
  logic                  data_wr;
  logic                  data_blk;
  logic                  pad_go;
  logic                  pad_end;
  logic [31:0]           pad_word;
  logic [31:0]           pad_data;

  assign slot_free = (used < USED_W'(BLK_SLOTS));
  assign full      = (state != ST_DATA) || !slot_free || desc_full;
  assign accept    = push && !full;
  assign take_byte = accept && byte_present;
  assign cnt_inc   = byte_cnt + 64'd1;
  assign n         = take_byte ? cnt_inc : byte_cnt;
  assign data_wr   = take_byte && (byte_cnt[1:0] == 2'd3);
  assign data_blk  = take_byte && (byte_cnt[5:0] == 6'd63);
  assign pad_go    = (state == ST_PAD) && slot_free && !desc_full;
  assign pad_end   = pad_go && (pidx == 4'd15);

  // first pad word: held message bytes, then the pad byte, then any zeros that fill the word
  always_comb begin
    case (byte_cnt[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc, PAD_BYTE};
    endcase
  end

  always_comb begin
    if (first) begin
      pad_data = pad_word;
    end else if (lenblk && (pidx == 4'd14)) begin
      pad_data = len[63:32];
    end else if (lenblk && (pidx == 4'd15)) begin
      pad_data = len[31:0];
    end else begin
      pad_data = 32'h0;
    end
  end

  always_comb begin
    wr.we = data_wr || pad_go;
    if (state == ST_PAD) begin
      wr.addr = {slot, pidx};
      wr.data = pad_data;
    end else begin
      wr.addr = {slot, byte_cnt[5:2]};
      wr.data = {acc, data_byte};
    end
  end

  assign desc_push      = data_blk || pad_end;
  assign desc.final_blk = (state == ST_PAD) && lenblk;

  always_comb begin
    case ({desc_push, blk_done})
      2'b10:   used_next = used + USED_W'(1);
      2'b01:   used_next = used - USED_W'(1);
      default: used_next = used;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      acc <= {acc[15:0], data_byte};
    end
    if (accept && last) begin
      len <= {n[60:0], 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_DATA;
      byte_cnt <= '0;
      slot     <= '0;
      used     <= '0;
      pidx     <= '0;
      first    <= 1'b0;
      lenblk   <= 1'b0;
    end else begin
      used <= used_next;
      if (desc_push) begin
        slot <= slot + SLOT_W'(1);
      end
      case (state)
        ST_DATA: begin
          if (take_byte) begin
            byte_cnt <= cnt_inc;
          end
          if (accept && last) begin
            state  <= ST_PAD;
            pidx   <= n[5:2];
            first  <= 1'b1;
            lenblk <= (n[5:2] < 4'd14);
          end
        end
        ST_PAD: begin
          if (pad_go) begin
            first <= 1'b0;
            pidx  <= pidx + 4'd1;
            if (pidx == 4'd15) begin
              if (lenblk) begin
                state    <= ST_DATA;
                byte_cnt <= '0;
              end else begin
                lenblk <= 1'b1;
              end
            end
          end
        end
        default: state <= ST_DATA;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(BLK_SLOTS))
    else $error("more blocks in flight than buffer slots");

  a_wr_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (used < USED_W'(BLK_SLOTS)))
    else $error("block buffer write into a busy slot");

endmodule
`default_nettype wire

[design/sha1he_core.sv]
// back end: 80-round compression, chaining words and digest register
`default_nettype none
module sha1he_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      desc_empty,
  input  wire sha1he_pkg::blk_desc_t     desc,
  output logic                           desc_pop,
  output logic [sha1he_pkg::RAM_AW-1:0]  rd_addr,
  input  wire logic [31:0]               rd_data,
  output logic                           blk_done,
  input  wire logic                      pop,
  output logic                           empty,
  output logic [31:0]                    digest_word0,
  output logic [31:0]                    digest_word1,
  output logic [31:0]                    digest_word2,
  output logic [31:0]                    digest_word3,
  output logic [31:0]                    digest_word4
);
  import sha1he_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]        state;
  logic [SLOT_W-1:0] rslot;
  logic              final_blk;
  logic [6:0]        t;
  logic [31:0]       a, b, c, d, e;
  logic [31:0]       h [5];
  logic [31:0]       w [BLK_WORDS];
  logic              out_valid;

  logic              out_free;
  logic [31:0]       wx;
  logic [31:0]       wnext;
  logic [31:0]       f;
  logic [31:0]       k;
  logic [31:0]       tmp;

  assign desc_pop = (state == ST_IDLE) && !desc_empty;
  assign blk_done = (state == ST_ADD);
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign rd_addr  = (state == ST_ROUND) ? {rslot, t[3:0] + 4'd1} : {rslot, 4'd0};

  assign wx    = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wnext = (t < 7'd16) ? rd_data : {wx[30:0], wx[31]};

  always_comb begin
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + wnext;

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[BLK_WORDS - 1] <= wnext;
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end else if (state == ST_LOAD) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end
    if ((state == ST_FIN) && out_free) begin
      digest_word0 <= h[0];
      digest_word1 <= h[1];
      digest_word2 <= h[2];
      digest_word3 <= h[3];
      digest_word4 <= h[4];
    end
    if ((state == ST_IDLE) && desc_pop) begin
      final_blk <= desc.final_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rslot     <= '0;
      t         <= '0;
      out_valid <= 1'b0;
      h[0]      <= IV0;
      h[1]      <= IV1;
      h[2]      <= IV2;
      h[3]      <= IV3;
      h[4]      <= IV4;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (desc_pop) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          t     <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          t <= t + 7'd1;
          if (t == 7'(NUM_ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          h[0]  <= h[0] + a;
          h[1]  <= h[1] + b;
          h[2]  <= h[2] + c;
          h[3]  <= h[3] + d;
          h[4]  <= h[4] + e;
          rslot <= rslot + SLOT_W'(1);
          state <= final_blk ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            h[0]      <= IV0;
            h[1]      <= IV1;
            h[2]      <= IV2;
            h[3]      <= IV3;
            h[4]      <= IV4;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_full_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> (t == 7'(NUM_ROUNDS)))
    else $error("block finished without all rounds");

  a_chain_restart: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && out_free) |=> (out_valid && (h[0] == IV0) && (h[4] == IV4)))
    else $error("digest not posted or chain not restarted");

endmodule
`default_nettype wire

[design/sha1_hash_engine_unit.sv]
// top level of the streaming sha-1 hash engine
//
//   channel   dir  handshake          payload
//   request   in   push / full        data_byte, byte_present, last
//   digest    out  empty / pop        digest_word0 .. digest_word4
//
// request side takes one byte per cycle while a block buffer slot is free
// compression runs each 64-byte block through the core load, round loop and add states,
// with two buffer slots, so one block can be written while another is hashed
// a last request blocks the request side while its padding words are written,
// longer while no buffer slot is free
// digest is posted after the final padding block has passed the core load, round and add states
// reset is synchronous, no memory clearing pass; a waiting digest stalls the core
`default_nettype none
module sha1_hash_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last,
  input  wire logic        pop,
  output logic             empty,
  output logic [31:0]      digest_word0,
  output logic [31:0]      digest_word1,
  output logic [31:0]      digest_word2,
  output logic [31:0]      digest_word3,
  output logic [31:0]      digest_word4
);
  import sha1he_pkg::*;

  ram_wr_t                       wr;
  blk_desc_t                     desc_in;
  blk_desc_t                     desc_out;
  logic [$bits(blk_desc_t)-1:0]  fifo_dout;
  logic                          desc_push;
  logic                          desc_pop;
  logic                          desc_empty;
  logic                          desc_full;
  logic                          blk_done;
  logic [RAM_AW-1:0]             rd_addr;
  logic [31:0]                   rd_data;

  assign desc_out = blk_desc_t'(fifo_dout);

  sha1he_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .full         (full),
    .desc_full    (desc_full),
    .blk_done     (blk_done),
    .desc_push    (desc_push),
    .desc         (desc_in),
    .wr           (wr)
  );

  sha1he_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_blk_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sha1he_fifo #(
    .WIDTH ($bits(blk_desc_t)),
    .DEPTH (BLK_SLOTS)
  ) u_desc_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .din   (desc_in),
    .pop   (desc_pop),
    .dout  (fifo_dout),
    .empty (desc_empty),
    .full  (desc_full)
  );

  sha1he_core u_core (
    .clk          (clk),
    .rst          (rst),
    .desc_empty   (desc_empty),
    .desc         (desc_out),
    .desc_pop     (desc_pop),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .blk_done     (blk_done),
    .pop          (pop),
    .empty        (empty),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

endmodule
`default_nettype wire
